FILE: sv/wdr_pkg.sv
// ----------------------------------------------------------------------------
// wdr_pkg: shared types and helpers for the windowed difficulty retarget
// Request structs, unit command struct, compact target decode.
// ----------------------------------------------------------------------------
package wdr_pkg;

	localparam int WINDOW  = 24;
	localparam int AVG_W   = 256;
	localparam int FAC_W   = 24;
	localparam int DIV_W   = 22;
	localparam int CARRY_W = FAC_W + 1;

	typedef struct packed {
		logic [31:0] compact_bits;
		logic [31:0] block_time;
		logic [31:0] height;
	} in_req_t;

	typedef struct packed {
		logic [31:0] next_compact;
		logic        hit_limit;
	} out_req_t;

	typedef enum logic [2:0] {
		OP_HOLD = 3'd0,
		OP_LOAD = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_SHL  = 3'd4
	} unit_op_t;

	typedef struct packed {
		unit_op_t         op;
		logic             clr;
		logic [AVG_W-1:0] data;
		logic [FAC_W-1:0] factor;
		logic [DIV_W-1:0] divisor;
	} unit_cmd_t;

	function automatic logic [AVG_W-1:0] decode(input logic [31:0] bits);
		logic [7:0]       size;
		logic [7:0]       sh;
		logic [AVG_W-1:0] x;
		size = bits[31:24];
		sh   = size - 8'd3;
		x    = {{(AVG_W-23){1'b0}}, bits[22:0]};
		if (size <= 8'd3) begin
			x = x >> {3'(8'd3 - size), 3'b000};
		end else if (sh < 8'd32) begin
			x = x << {sh[4:0], 3'b000};
		end else begin
			x = '0;
		end
		return x;
	endfunction

endpackage

FILE: sv/windowed_difficulty_retarget.sv
// ----------------------------------------------------------------------------
// windowed_difficulty_retarget: windowed-average difficulty retarget
// Averages decoded targets over a window of blocks, scales by clamped
// timespan, caps at the limit and returns the compact target.
// ----------------------------------------------------------------------------
//  channel  | signals                         | dir
//  ---------+---------------------------------+-----
//  cfg      | cfg_we, cfg_index, cfg_data     | in
//  in       | in_valid, in_ready, in_data     | in
//  out      | out_valid, out_ready, out_data  | out
//
//  A counted item beyond the first runs a multiply-add pass, then a divide.
//  The last item of a window adds scale and divide passes (skipped for an
//  invalid span), normalize and control states; other items stay in idle.
//  in_ready is high only when the sequencer is idle; the result sits in an
//  output register until taken. Reset clears all window state.
// ----------------------------------------------------------------------------
module windowed_difficulty_retarget (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  wdr_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output wdr_pkg::out_req_t out_data
);
	import wdr_pkg::*;

	localparam logic CFG_LIMIT   = 1'b0;
	localparam logic CFG_SPACING = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_SPAN  = 8'b0000_1000,
		ST_CLAMP = 8'b0001_0000,
		ST_CMP   = 8'b0010_0000,
		ST_NORM  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [31:0]        limit_q;
	logic [16:0]        spacing_q;
	logic [8:0]         cnt_q;
	logic [4:0]         items_q;
	logic [4:0]         blocks_q;
	logic [31:0]        prev_q;
	logic signed [39:0] sum_q;
	logic               young_q;
	logic               stop_q;
	logic               last_q;
	logic               fin_q;
	logic               ok_q;
	logic               hit_q;
	logic [FAC_W-1:0]   factor_q;
	logic [DIV_W-1:0]   divisor_q;
	logic [DIV_W-1:0]   span_q;
	logic               out_valid_q;
	out_req_t           out_q;

	unit_cmd_t          cmd;
	logic [AVG_W-1:0]   acc;
	logic [AVG_W-1:0]   limit_dec;
	logic               take;
	logic               ty;
	logic               counting;
	logic [4:0]         n_blocks;
	logic [4:0]         items_n;
	logic [46:0]        third_prod;
	logic [DIV_W-1:0]   third;
	logic [23:0]        span3;
	logic [23:0]        actual;
	logic [2:0]         pad;
	logic [7:0]         enc_size;
	logic [23:0]        man;
	logic [31:0]        enc;

	wdr_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.acc    (acc)
	);

	assign limit_dec = decode(limit_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign ty       = young_q || (items_q == '0 && in_data.height < 32'(WINDOW));
	assign counting = !ty && !stop_q && in_data.height != '0;
	assign n_blocks = blocks_q + 5'd1;
	assign items_n  = items_q + 5'd1;

	assign third_prod = 47'(span_q) * 47'(24'hAAAAAB);
	assign third      = DIV_W'(third_prod >> 25);
	assign span3      = 24'(span_q) + {1'b0, span_q, 1'b0};

	always_comb begin
		if (sum_q < $signed({18'b0, third})) begin
			actual = 24'(third);
		end else if (sum_q > $signed({16'b0, span3})) begin
			actual = span3;
		end else begin
			actual = sum_q[23:0];
		end
	end

	always_comb begin
		logic [5:0] sz;
		sz  = 6'((10'(cnt_q) + 10'd7) >> 3);
		pad = 3'(4'd8 - {1'b0, cnt_q[2:0]});
		man = acc[AVG_W-1 -: 24] >> pad;
		enc_size = {2'b0, sz};
		if (man[23]) begin
			man      = man >> 8;
			enc_size = enc_size + 8'd1;
		end
		enc = {enc_size, man};
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_HOLD;
		cmd.factor  = factor_q;
		cmd.divisor = divisor_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && counting) begin
					cmd.data = decode(in_data.compact_bits);
					if (n_blocks == 5'd1) begin
						cmd.op = OP_LOAD;
					end else begin
						cmd.clr = 1'b1;
					end
				end
			end
			ST_MUL:  cmd.op = OP_MUL;
			ST_DIV:  cmd.op = OP_DIV;
			ST_CLAMP: begin
				if (!ok_q) begin
					cmd.op   = OP_LOAD;
					cmd.data = limit_dec;
				end else begin
					cmd.clr = 1'b1;
				end
			end
			ST_CMP: begin
				if (acc > limit_dec) begin
					cmd.op   = OP_LOAD;
					cmd.data = limit_dec;
				end
			end
			ST_NORM: begin
				if (!acc[AVG_W-1] && cnt_q != '0) begin
					cmd.op = OP_SHL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= 32'd504365055;
			spacing_q   <= 17'd150;
			cnt_q       <= '0;
			items_q     <= '0;
			blocks_q    <= '0;
			prev_q      <= '0;
			sum_q       <= '0;
			young_q     <= 1'b0;
			stop_q      <= 1'b0;
			last_q      <= 1'b0;
			fin_q       <= 1'b0;
			ok_q        <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LIMIT:   limit_q   <= cfg_data;
					CFG_SPACING: spacing_q <= cfg_data[16:0];
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						items_q <= items_n;
						last_q  <= (items_n == 5'(WINDOW));
						young_q <= ty;
						if (!ty && !stop_q && in_data.height == '0) begin
							stop_q <= 1'b1;
						end
						if (counting) begin
							blocks_q <= n_blocks;
							prev_q   <= in_data.block_time;
							if (prev_q != '0) begin
								sum_q <= sum_q + ($signed({8'b0, prev_q})
									- $signed({8'b0, in_data.block_time}));
							end
						end
						if (counting && n_blocks != 5'd1) begin
							factor_q  <= FAC_W'(n_blocks);
							divisor_q <= DIV_W'(n_blocks) + DIV_W'(1);
							cnt_q     <= 9'd7;
							state_q   <= ST_MUL;
						end else if (items_n == 5'(WINDOW)) begin
							state_q <= ST_SPAN;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						cnt_q   <= 9'd255;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 9'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (fin_q) begin
							state_q <= ST_CMP;
						end else if (last_q) begin
							state_q <= ST_SPAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q - 9'd1;
					end
				end
				ST_SPAN: begin
					span_q  <= DIV_W'(22'(blocks_q) * 22'(spacing_q));
					ok_q    <= !young_q && blocks_q != '0 && spacing_q != '0;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (!ok_q) begin
						hit_q   <= 1'b1;
						cnt_q   <= 9'd256;
						state_q <= ST_NORM;
					end else begin
						factor_q  <= actual;
						divisor_q <= span_q;
						fin_q     <= 1'b1;
						cnt_q     <= 9'd7;
						state_q   <= ST_MUL;
					end
				end
				ST_CMP: begin
					hit_q   <= acc > limit_dec;
					cnt_q   <= 9'd256;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (acc[AVG_W-1] || cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 9'd1;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						items_q     <= '0;
						blocks_q    <= '0;
						prev_q      <= '0;
						sum_q       <= '0;
						young_q     <= 1'b0;
						stop_q      <= 1'b0;
						last_q      <= 1'b0;
						fin_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_q.next_compact <= enc;
			out_q.hit_limit    <= hit_q;
		end
	end

endmodule

FILE: sv/wdr_unit.sv
// ----------------------------------------------------------------------------
// wdr_unit: shared 256-bit arithmetic unit
// One accumulator worked word-serial for multiply-add, bit-serial for
// division by a narrow divisor, and single-bit left shifts.
// ----------------------------------------------------------------------------
module wdr_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wdr_pkg::unit_cmd_t        cmd,
	output logic [wdr_pkg::AVG_W-1:0] acc
);
	import wdr_pkg::*;

	logic [AVG_W-1:0]   acc_q;
	logic [AVG_W-1:0]   add_q;
	logic [CARRY_W-1:0] carry_q;
	logic [DIV_W-1:0]   rem_q;

	logic [56:0]        prod;
	logic [DIV_W:0]     trial;
	logic               ge;

	assign prod  = 57'(acc_q[31:0]) * 57'(cmd.factor) + 57'(carry_q) + 57'(add_q[31:0]);
	assign trial = {rem_q, acc_q[AVG_W-1]};
	assign ge    = trial >= {1'b0, cmd.divisor};
	assign acc   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			rem_q   <= '0;
		end else begin
			unique case (cmd.op)
				OP_MUL: begin
					carry_q <= prod[56:32];
					rem_q   <= '0;
				end
				OP_DIV: begin
					carry_q <= '0;
					rem_q   <= ge ? DIV_W'(trial - {1'b0, cmd.divisor}) : trial[DIV_W-1:0];
				end
				default: begin
				end
			endcase
			if (cmd.clr) begin
				carry_q <= '0;
				rem_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: acc_q <= cmd.data;
			OP_MUL: begin
				acc_q <= {prod[31:0], acc_q[AVG_W-1:32]};
				add_q <= {32'b0, add_q[AVG_W-1:32]};
			end
			OP_DIV:  acc_q <= {acc_q[AVG_W-2:0], ge};
			OP_SHL:  acc_q <= {acc_q[AVG_W-2:0], 1'b0};
			default: begin
			end
		endcase
		if (cmd.clr) begin
			add_q <= cmd.data;
		end
	end

endmodule

FILE: tb/wdr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wdr_checker: request monitor and result predictor for the retarget block
// Follows config writes and accepted input requests, forms the expected
// compact target at the end of every window and compares each output request
// against the oldest expected one.
// ----------------------------------------------------------------------------
module wdr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  wdr_pkg::in_req_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  wdr_pkg::out_req_t out_data,
	output int                pending,
	output int                fails
);
	import wdr_pkg::*;

	localparam logic CFG_LIMIT   = 1'b0;
	localparam logic CFG_SPACING = 1'b1;

	logic [31:0]  limit_bits;
	logic [16:0]  spacing;
	logic [255:0] avg_target;
	int unsigned  n_counted;
	int unsigned  n_seen;
	logic [31:0]  last_time;
	longint       gap_sum;
	bit           young_chain;
	bit           halted;
	out_req_t     expected_q[$];

	function automatic logic [255:0] unpack_target(input logic [31:0] b);
		int unsigned sz;
		sz = b[31:24];
		if (sz <= 3)
			return 256'(b[22:0]) >> (8 * (3 - sz));
		else if (sz - 3 < 32)
			return 256'(b[22:0]) << (8 * (sz - 3));
		return '0;
	endfunction

	function automatic logic [31:0] pack_target(input logic [255:0] a);
		int unsigned nb;
		int unsigned sz;
		logic [255:0] t;
		logic [31:0]  c;
		nb = 0;
		for (int i = 255; i >= 0; i--) begin
			if (a[i] && nb == 0)
				nb = i + 1;
		end
		sz = (nb + 7) / 8;
		if (sz <= 3) begin
			c = ({8'h00, a[23:0]} << (8 * (3 - sz))) & 32'h00ff_ffff;
		end else begin
			t = a >> (8 * (sz - 3));
			c = {8'h00, t[23:0]};
		end
		if (c[23]) begin
			c = c >> 8;
			sz++;
		end
		return {sz[7:0], c[23:0]};
	endfunction

	task automatic clear_window();
		avg_target  = '0;
		n_counted   = 0;
		n_seen      = 0;
		last_time   = '0;
		gap_sum     = 0;
		young_chain = 0;
		halted      = 0;
	endtask

	task automatic absorb_block(input in_req_t r);
		logic [255:0] lim;
		logic [255:0] res;
		longint       span;
		longint       actual;
		out_req_t     e;
		if (n_seen == 0 && r.height < WINDOW)
			young_chain = 1;
		if (!young_chain && !halted) begin
			if (r.height == 0) begin
				halted = 1;
			end else begin
				n_counted++;
				if (n_counted == 1) begin
					avg_target = unpack_target(r.compact_bits);
				end else begin
					avg_target = avg_target * 256'(n_counted);
					avg_target = avg_target + unpack_target(r.compact_bits);
					avg_target = avg_target / 256'(n_counted + 1);
				end
				if (last_time != 0)
					gap_sum += longint'(last_time) - longint'(r.block_time);
				last_time = r.block_time;
			end
		end
		n_seen++;
		if (n_seen < WINDOW)
			return;
		lim = unpack_target(limit_bits);
		res = lim;
		e.hit_limit = 1'b1;
		if (!young_chain && n_counted != 0 && spacing != 0) begin
			span   = longint'(n_counted) * longint'(spacing);
			actual = gap_sum;
			if (actual < span / 3)
				actual = span / 3;
			if (actual > span * 3)
				actual = span * 3;
			res = avg_target * 256'(actual[31:0]);
			res = res / 256'(span[31:0]);
			if (res > lim)
				res = lim;
			else
				e.hit_limit = 1'b0;
		end
		e.next_compact = pack_target(res);
		expected_q.push_back(e);
		clear_window();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, exp_v);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_bits = 32'd504365055;
			spacing    = 17'd150;
			clear_window();
			expected_q.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LIMIT)
					limit_bits = cfg_data;
				else if (cfg_index == CFG_SPACING)
					spacing = cfg_data[16:0];
			end
			if (in_valid && in_ready)
				absorb_block(in_data);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected request", out_data.next_compact, '0);
				end else begin
					out_req_t e;
					e = expected_q.pop_front();
					if (out_data.next_compact !== e.next_compact)
						report("next_compact", out_data.next_compact, e.next_compact);
					if (out_data.hit_limit !== e.hit_limit)
						report("hit_limit", 32'(out_data.hit_limit), 32'(e.hit_limit));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the windowed difficulty retarget
// Drives windows of chain blocks (well-formed, young, height-stopped and
// random), rewrites the limit and spacing between windows, and varies
// sender idling and receiver stalls across phases.
// ----------------------------------------------------------------------------
module tb;
	import wdr_pkg::*;

	localparam logic CFG_LIMIT   = 1'b0;
	localparam logic CFG_SPACING = 1'b1;

	typedef enum int {WIN_NORMAL, WIN_YOUNG, WIN_STOP, WIN_NOISE} win_kind_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	logic     cfg_index;
	logic [31:0] cfg_data;
	logic     in_valid;
	logic     in_ready;
	in_req_t  in_data;
	logic     out_valid;
	logic     out_ready;
	out_req_t out_data;
	int       pending;
	int       fails;
	int       idle_pct;
	int       stall_pct;
	logic [16:0] cur_spacing;

	windowed_difficulty_retarget i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	wdr_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.pending  (pending),
		.fails    (fails)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	task automatic send_block(input in_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain, then let the block settle before touching registers
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SPACING)
			cur_spacing = val[16:0];
	endtask

	function automatic logic [31:0] rand_compact();
		case ($urandom_range(9))
			0: return $urandom();
			1: return {8'($urandom_range(0, 3)), 24'($urandom())};
			default: return {8'($urandom_range(4, 32)), 24'($urandom())};
		endcase
	endfunction

	task automatic send_window(input win_kind_t kind);
		in_req_t r;
		logic [31:0] h;
		logic [31:0] t;
		int stop_at;
		h = (kind == WIN_YOUNG) ? 32'($urandom_range(0, WINDOW - 1))
			: ($urandom_range(3) == 0 ? 32'hffff_ffff - 32'($urandom_range(50))
			: 32'($urandom_range(WINDOW, 2000000)));
		t = $urandom();
		stop_at = $urandom_range(1, WINDOW - 1);
		for (int i = 0; i < WINDOW; i++) begin
			r.compact_bits = rand_compact();
			r.block_time   = t;
			r.height       = h - i;
			if (kind == WIN_STOP && i == stop_at)
				r.height = '0;
			if ($urandom_range(30) == 0)
				r.block_time = '0;
			if (kind == WIN_NOISE) begin
				r.compact_bits = $urandom();
				r.block_time   = $urandom();
				r.height       = $urandom();
			end
			send_block(r);
			case ($urandom_range(9))
				0: t = t - $urandom();
				1: t = t + 32'($urandom_range(0, 4 * cur_spacing + 10));
				default: t = t - 32'($urandom_range(0, 4 * cur_spacing + 1));
			endcase
		end
	endtask

	initial begin
		win_kind_t kind;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_LIMIT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		idle_pct  = 0;
		stall_pct = 0;
		cur_spacing = 17'd150;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed windows
		send_window(WIN_YOUNG);
		wait_idle();
		write_reg(CFG_SPACING, 32'd1);
		send_window(WIN_STOP);
		wait_idle();
		write_reg(CFG_LIMIT, 32'hffff_ffff);
		write_reg(CFG_SPACING, 32'd86400);
		send_window(WIN_NORMAL);
		wait_idle();
		write_reg(CFG_LIMIT, 32'h0000_0000);
		write_reg(CFG_SPACING, 32'h1_ffff);
		send_window(WIN_NORMAL);
		wait_idle();
		write_reg(CFG_SPACING, 32'd0);
		send_window(WIN_NORMAL);
		wait_idle();
		write_reg(CFG_LIMIT, 32'h2100_ffff);
		write_reg(CFG_SPACING, 32'd150);

		for (int w = 0; w < 52; w++) begin
			case (w / 13)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			if ($urandom_range(3) == 0) begin
				wait_idle();
				case ($urandom_range(5))
					0: write_reg(CFG_LIMIT, $urandom());
					1: write_reg(CFG_LIMIT, {8'($urandom_range(28, 34)), 24'($urandom())});
					2: write_reg(CFG_SPACING, 32'($urandom_range(1, 86400)));
					3: write_reg(CFG_SPACING, 32'($urandom_range(0, 17'h1ffff)));
					default: write_reg(CFG_SPACING, 32'($urandom_range(30, 600)));
				endcase
			end
			case ($urandom_range(9))
				0: kind = WIN_YOUNG;
				1: kind = WIN_STOP;
				2: kind = WIN_NOISE;
				default: kind = WIN_NORMAL;
			endcase
			send_window(kind);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (600) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
sv/wdr_pkg.sv
sv/wdr_unit.sv
sv/windowed_difficulty_retarget.sv
tb/wdr_checker.sv
tb/tb.sv
